// ----- rtl/core/pfe_pkg.sv -----
// shared constants, types and helpers of the printf format engine
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int ARG_WIDTH  = 32;
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 31;

    // decimal digits of the widest magnitude, log10(2) ~ 0.30103
    localparam int DEC_DIGITS = (ARG_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (ARG_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(ARG_WIDTH);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CH_I       = 8'h69;
    localparam logic [CHAR_W-1:0] CH_U       = 8'h75;
    localparam logic [CHAR_W-1:0] CH_X_LO    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_S       = 8'h73;
    localparam logic [CHAR_W-1:0] DIGIT_OFS  = 8'd48;
    localparam logic [CHAR_W-1:0] ALPHA_LO   = 8'd87;
    localparam logic [CHAR_W-1:0] ALPHA_UP   = 8'd55;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 2'd0,
        CMD_ARG    = 2'd1,
        CMD_STRING = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ARMED = 3'd1,
        PH_CHR   = 3'd2,
        PH_DEC   = 3'd3,
        PH_UNS   = 3'd4,
        PH_HXL   = 3'd5,
        PH_HXU   = 3'd6,
        PH_STR   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic conv_step;
        logic dig_shift;
    } t_rad_ctl;

    typedef struct packed {
        logic       conv_done;
        logic       top_zero;
        logic       left_one;
        logic [3:0] top_digit;
    } t_rad_sts;

    function automatic t_phase select_conv(input logic [CHAR_W-1:0] b);
        t_phase ph;
        unique case (b) inside
            CH_C:       ph = PH_CHR;
            CH_D, CH_I: ph = PH_DEC;
            CH_U:       ph = PH_UNS;
            CH_X_LO:    ph = PH_HXL;
            CH_X_UP:    ph = PH_HXU;
            CH_S:       ph = PH_STR;
            default:    ph = PH_IDLE;
        endcase
        return ph;
    endfunction

endpackage

// ----- rtl/core/pfe_if.sv -----
// request and result channel interfaces of the printf format engine
`timescale 1ns / 1ps

interface pfe_in_if;
    import pfe_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [CHAR_W-1:0]   byte_value;
    logic [WORD_W-1:0]   arg_word;
    logic                string_last;

    modport source (output valid, command, byte_value, arg_word, string_last, input ready);
    modport sink   (input valid, command, byte_value, arg_word, string_last, output ready);
endinterface

interface pfe_out_if;
    import pfe_pkg::*;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   out_char;
    logic                run_last;
    logic [COUNT_W-1:0]  total_count;
    logic                done_res;

    modport source (output valid, out_char, run_last, total_count, done_res, input ready);
    modport sink   (input valid, out_char, run_last, total_count, done_res, output ready);
endinterface

// ----- rtl/core/pfe_radix.sv -----
// bit-serial binary to bcd converter and digit shifter
`timescale 1ns / 1ps

module pfe_radix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_rad_ctl i_ctl,
    input  logic [pfe_pkg::ARG_WIDTH-1:0] i_value,
    output pfe_pkg::t_rad_sts o_sts
);
    import pfe_pkg::*;

    logic [ARG_WIDTH-1:0] r_mag;
    logic [DIG_W-1:0]     r_dig;
    logic [BIT_CNT_W-1:0] r_bits;
    logic [LEFT_W-1:0]    r_left;
    logic [DIG_W-1:0]     w_adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        logic [3:0] d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = r_dig[4*i +: 4];
            w_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_left <= '0;
        end else if (i_ctl.load_dec) begin
            r_mag  <= i_value;
            r_dig  <= '0;
            r_bits <= BIT_CNT_W'(ARG_WIDTH - 1);
        end else if (i_ctl.load_hex) begin
            r_dig  <= DIG_W'(i_value);
            r_left <= LEFT_W'(NUM_DIGITS);
        end else if (i_ctl.conv_step) begin
            r_dig  <= {w_adj[DIG_W-2:0], r_mag[ARG_WIDTH-1]};
            r_mag  <= {r_mag[ARG_WIDTH-2:0], 1'b0};
            r_bits <= r_bits - BIT_CNT_W'(1);
            if (r_bits == '0) begin
                r_left <= LEFT_W'(NUM_DIGITS);
            end
        end else if (i_ctl.dig_shift) begin
            r_dig  <= {r_dig[DIG_W-5:0], 4'b0000};
            r_left <= r_left - LEFT_W'(1);
        end
    end

    assign o_sts.conv_done = (r_bits == '0);
    assign o_sts.top_zero  = (r_dig[DIG_W-1 -: 4] == 4'd0);
    assign o_sts.left_one  = (r_left == LEFT_W'(1));
    assign o_sts.top_digit = r_dig[DIG_W-1 -: 4];

endmodule

// ----- rtl/core/printf_format_engine_unit.sv -----
// top level of the streaming printf format engine
`timescale 1ns / 1ps

//  channel | direction | payload                                         | handshake
//  i_in    | request   | command, byte_value, arg_word, string_last      | valid / ready
//  o_out   | result    | out_char, run_last, total_count, done_res       | valid / ready
//
//  format bytes, string bytes, %c words and end of format are handled in the idle state
//  %d/%i/%u: accept, then a minus sign when negative, then the shift-and-adjust loop
//  over the ARG_WIDTH bits in pfe_radix, then leading-zero skip and digit output;
//  %x/%X skip the sign and the loop and go straight to leading-zero skip
//  the single output register stalls digit output and requests while o_out is full
//  synchronous active-low reset: parser idle, count zero, no result pending

module printf_format_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_in_if.sink    i_in,
    pfe_out_if.source o_out
);
    import pfe_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_upper;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] w_count_inc;

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_done;

    logic w_ov_free;
    logic w_in_ready;
    logic w_accept;
    t_cmd w_cmd;

    // one character or end report per cycle at most
    logic              w_emit;
    logic [CHAR_W-1:0] w_emit_char;
    logic              w_emit_last;
    logic              w_emit_done;

    logic [ARG_WIDTH-1:0] w_arg;
    logic                 w_neg;
    logic [ARG_WIDTH-1:0] w_mag;
    logic [CHAR_W-1:0]    w_digit_char;

    t_rad_ctl w_ctl;
    t_rad_sts w_sts;

    // output slot free when empty or being drained this cycle
    assign w_ov_free  = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == ST_IDLE) && w_ov_free;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_cmd      = t_cmd'(i_in.command);
    assign i_in.ready = w_in_ready;

    // argument in the configured width, two's complement magnitude for %d
    assign w_arg = ARG_WIDTH'(i_in.arg_word);
    assign w_neg = (r_phase == PH_DEC) && w_arg[ARG_WIDTH-1];
    assign w_mag = w_neg ? ARG_WIDTH'(~w_arg + ARG_WIDTH'(1)) : w_arg;

    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);

    // digit to ascii, letters only ever reached by hex words
    assign w_digit_char = (w_sts.top_digit < 4'd10)
                        ? {4'b0000, w_sts.top_digit} + DIGIT_OFS
                        : {4'b0000, w_sts.top_digit} + (r_upper ? ALPHA_UP : ALPHA_LO);

    pfe_radix u_radix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_value (w_mag),
        .o_sts   (w_sts)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_cmd == CMD_ARG)) begin
                    case (r_phase) inside
                        PH_DEC:         n_state = w_neg ? ST_SIGN : ST_CONV;
                        PH_UNS:         n_state = ST_CONV;
                        PH_HXL, PH_HXU: n_state = ST_SKIP;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SIGN: begin
                if (w_ov_free) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (w_sts.conv_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!w_sts.top_zero || w_sts.left_one) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_ov_free && w_sts.left_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: parser phase, emission and radix control
    always_comb begin
        n_phase     = r_phase;
        w_emit      = 1'b0;
        w_emit_char = CH_NUL;
        w_emit_last = 1'b1;
        w_emit_done = 1'b0;
        w_ctl       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_FORMAT: begin
                            if (r_phase == PH_IDLE) begin
                                if (i_in.byte_value == CH_PERCENT) begin
                                    n_phase = PH_ARMED;
                                end else if (i_in.byte_value != CH_NUL) begin
                                    w_emit      = 1'b1;
                                    w_emit_char = i_in.byte_value;
                                end
                            end else if (r_phase == PH_ARMED) begin
                                if (i_in.byte_value == CH_PERCENT) begin
                                    w_emit      = 1'b1;
                                    w_emit_char = CH_PERCENT;
                                    n_phase     = PH_IDLE;
                                end else begin
                                    n_phase = select_conv(i_in.byte_value);
                                end
                            end
                            // a format byte while an argument is pending is dropped
                        end
                        CMD_ARG: begin
                            case (r_phase) inside
                                PH_CHR: begin
                                    w_emit      = 1'b1;
                                    w_emit_char = i_in.arg_word[CHAR_W-1:0];
                                    n_phase     = PH_IDLE;
                                end
                                PH_DEC, PH_UNS: begin
                                    w_ctl.load_dec = 1'b1;
                                    n_phase        = PH_IDLE;
                                end
                                PH_HXL, PH_HXU: begin
                                    w_ctl.load_hex = 1'b1;
                                    n_phase        = PH_IDLE;
                                end
                                default: ;
                            endcase
                        end
                        CMD_STRING: begin
                            if (r_phase == PH_STR) begin
                                if (i_in.byte_value != CH_NUL) begin
                                    w_emit      = 1'b1;
                                    w_emit_char = i_in.byte_value;
                                end
                                if (i_in.string_last) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                        CMD_END: begin
                            w_emit_done = 1'b1;
                            n_phase     = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SIGN: begin
                if (w_ov_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_MINUS;
                    w_emit_last = 1'b0;
                end
            end
            ST_CONV: begin
                w_ctl.conv_step = 1'b1;
            end
            ST_SKIP: begin
                // drop leading zero digits, keeping at least one
                if (w_sts.top_zero && !w_sts.left_one) begin
                    w_ctl.dig_shift = 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_ov_free) begin
                    w_emit          = 1'b1;
                    w_emit_char     = w_digit_char;
                    w_emit_last     = w_sts.left_one;
                    w_ctl.dig_shift = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (w_emit_done) begin
                r_count <= '0;
            end else if (w_emit) begin
                r_count <= w_count_inc;
            end
            if (w_emit || w_emit_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload and hex letter case, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_cmd == CMD_ARG)) begin
            r_upper <= (r_phase == PH_HXU);
        end
        if (w_emit_done) begin
            r_out_char  <= CH_NUL;
            r_out_last  <= 1'b1;
            r_out_count <= r_count;
            r_out_done  <= 1'b1;
        end else if (w_emit) begin
            r_out_char  <= w_emit_char;
            r_out_last  <= w_emit_last;
            r_out_count <= w_count_inc;
            r_out_done  <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.run_last    = r_out_last;
    assign o_out.total_count = r_out_count;
    assign o_out.done_res    = r_out_done;

endmodule

// ----- tb/sv/tb_printf_format_engine_unit.sv -----
// testbench of the printf format engine: directed and random streams against a predictor
`timescale 1ns / 1ps

module tb_printf_format_engine_unit;
    import pfe_pkg::*;

    // run length and stall shaping
    localparam int LIMIT_CYCLES = 400000;   // far above the slowest legal run
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 60;       // a %d request plus margin
    localparam int ITEM_TARGET  = 320;

    // characters the package does not name
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
    localparam logic [CHAR_W-1:0] CH_Q     = 8'h71;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    // one emitted character as it should leave the block
    typedef struct {
        logic [CHAR_W-1:0]  out_char;
        logic               run_last;
        logic [COUNT_W-1:0] total_count;
        logic               done_res;
    } t_char_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pfe_in_if  req_if ();
    pfe_out_if res_if ();

    printf_format_engine_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state: parser phase and running character count
    t_phase             fmt_phase  = PH_IDLE;
    logic [COUNT_W-1:0] char_total = '0;

    // characters still owed by the block, oldest first
    t_char_res pending_chars[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // idling control: random gaps on both sides of the block, hold-off on the result side
    bit gaps_on   = 1'b1;
    int hold_gen  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // every character bumps the saturating count before it is reported
    function automatic void emit_char(input logic [CHAR_W-1:0] ch);
        if (char_total != COUNT_MAX)
            char_total = char_total + 1'b1;
        pending_chars.push_back('{ch, 1'b0, char_total, 1'b0});
    endfunction

    // digits most significant first, no leading zeros, a lone zero for zero
    function automatic void emit_number(input logic [63:0] mag, input logic [63:0] base,
                                        input logic [CHAR_W-1:0] alpha);
        logic [CHAR_W-1:0] digits[$];
        logic [63:0]       d;
        do begin
            d = mag % base;
            digits.push_front((d < 10) ? DIGIT_OFS + d[7:0] : alpha + d[7:0]);
            mag = mag / base;
        end while (mag != 0);
        foreach (digits[k])
            emit_char(digits[k]);
    endfunction

    // works out the characters that one accepted request causes
    function automatic void predict_chars(input t_cmd cmd, input logic [CHAR_W-1:0] b,
                                          input logic [WORD_W-1:0] w, input logic last);
        logic [63:0] mask;
        logic [63:0] mag;
        int          depth_before;
        t_char_res   tail;
        mask         = (64'd1 << ARG_WIDTH) - 64'd1;
        mag          = {32'd0, w} & mask;
        depth_before = pending_chars.size();
        case (cmd)
            CMD_FORMAT: begin
                if (fmt_phase == PH_IDLE) begin
                    // plain text, a zero byte is swallowed
                    if (b == CH_PERCENT)
                        fmt_phase = PH_ARMED;
                    else if (b != CH_NUL)
                        emit_char(b);
                end else if (fmt_phase == PH_ARMED) begin
                    // conversion letter, anything unknown (p and zero too) disarms silently
                    case (b) inside
                        CH_PERCENT: begin
                            emit_char(CH_PERCENT);
                            fmt_phase = PH_IDLE;
                        end
                        CH_C:       fmt_phase = PH_CHR;
                        CH_D, CH_I: fmt_phase = PH_DEC;
                        CH_U:       fmt_phase = PH_UNS;
                        CH_X_LO:    fmt_phase = PH_HXL;
                        CH_X_UP:    fmt_phase = PH_HXU;
                        CH_S:       fmt_phase = PH_STR;
                        default:    fmt_phase = PH_IDLE;
                    endcase
                end
                // format bytes while an argument is pending are dropped
            end
            CMD_ARG: begin
                if (fmt_phase >= PH_CHR && fmt_phase <= PH_HXU) begin
                    case (fmt_phase)
                        PH_CHR: emit_char(mag[7:0]);
                        PH_DEC: begin
                            // two's complement, the most negative value prints its magnitude
                            if (mag[ARG_WIDTH-1]) begin
                                emit_char(CH_MINUS);
                                mag = (~mag + 64'd1) & mask;
                            end
                            emit_number(mag, 64'd10, DIGIT_OFS);
                        end
                        PH_UNS:  emit_number(mag, 64'd10, DIGIT_OFS);
                        PH_HXL:  emit_number(mag, 64'd16, ALPHA_LO);
                        default: emit_number(mag, 64'd16, ALPHA_UP);
                    endcase
                    fmt_phase = PH_IDLE;
                end
            end
            CMD_STRING: begin
                if (fmt_phase == PH_STR) begin
                    if (b != CH_NUL)
                        emit_char(b);
                    if (last)
                        fmt_phase = PH_IDLE;
                end
            end
            default: begin
                // end of format: one report with the total, then everything clears
                pending_chars.push_back('{CH_NUL, 1'b1, char_total, 1'b1});
                char_total = '0;
                fmt_phase  = PH_IDLE;
            end
        endcase
        if (pending_chars.size() > depth_before) begin
            tail          = pending_chars.pop_back();
            tail.run_last = 1'b1;
            pending_chars.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // request monitor and result checker, both on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected result: out_char %0h total_count %0d done_res %0b",
                       res_if.out_char, res_if.total_count, res_if.done_res);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (res_if.out_char !== want.out_char) begin
                    $error("out_char: expected %0h actual %0h", want.out_char, res_if.out_char);
                    mismatch_count++;
                end
                if (res_if.run_last !== want.run_last) begin
                    $error("run_last: expected %0b actual %0b", want.run_last, res_if.run_last);
                    mismatch_count++;
                end
                if (res_if.total_count !== want.total_count) begin
                    $error("total_count: expected %0d actual %0d",
                           want.total_count, res_if.total_count);
                    mismatch_count++;
                end
                if (res_if.done_res !== want.done_res) begin
                    $error("done_res: expected %0b actual %0b", want.done_res, res_if.done_res);
                    mismatch_count++;
                end
            end
        end
        // a request accepted at this edge only adds to the back of the queue
        if (i_rst_n && req_if.valid && req_if.ready)
            predict_chars(t_cmd'(req_if.command), req_if.byte_value, req_if.arg_word,
                          req_if.string_last);
    end

    // result side readiness: random gaps, or a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (gaps_on) begin
            res_if.ready <= ($urandom_range(0, 99) >= 25);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------

    // offers one request from a falling edge and returns at the edge that takes it
    task automatic send_request(input t_cmd cmd, input logic [CHAR_W-1:0] b,
                                input logic [WORD_W-1:0] w, input logic last);
        @(negedge i_clk);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 25) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.byte_value  <= b;
        req_if.arg_word    <= w;
        req_if.string_last <= last;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        items_sent++;
    endtask

    // unused fields carry random junk so their bits toggle too
    task automatic send_fmt(input logic [CHAR_W-1:0] b);
        send_request(CMD_FORMAT, b, $urandom, 1'($urandom));
    endtask

    task automatic send_arg(input logic [WORD_W-1:0] w);
        send_request(CMD_ARG, 8'($urandom), w, 1'($urandom));
    endtask

    task automatic send_str(input logic [CHAR_W-1:0] b, input logic last);
        send_request(CMD_STRING, b, $urandom, last);
    endtask

    task automatic send_end();
        send_request(CMD_END, 8'($urandom), $urandom, 1'($urandom));
    endtask

    // sender goes quiet until the block owes nothing more
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 999);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_conv();
        case ($urandom_range(0, 5))
            0:       return CH_C;
            1:       return CH_D;
            2:       return CH_I;
            3:       return CH_U;
            4:       return CH_X_LO;
            default: return CH_X_UP;
        endcase
    endfunction

    // one piece of a format stream: mostly well formed, some noise
    task automatic send_random_segment();
        int                kind;
        int                len;
        logic [CHAR_W-1:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // plain text, now and then any byte at all
            b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
            send_fmt(b);
        end else if (kind < 60) begin
            send_fmt(CH_PERCENT);
            send_fmt(pick_conv());
            if ($urandom_range(0, 19) == 0)
                send_fmt(8'($urandom));         // stray byte while the word is pending
            send_arg(pick_arg());
        end else if (kind < 72) begin
            len = $urandom_range(1, 6);
            send_fmt(CH_PERCENT);
            send_fmt(CH_S);
            for (int k = 0; k < len; k++) begin
                b = ($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(1, 255));
                send_str(b, k == len - 1);
            end
        end else if (kind < 77) begin
            send_fmt(CH_PERCENT);
            send_fmt(CH_PERCENT);
        end else if (kind < 82) begin
            send_fmt(CH_PERCENT);
            send_fmt(($urandom_range(0, 1) == 0) ? CH_P : 8'($urandom));
        end else if (kind < 88) begin
            send_end();
        end else begin
            send_request(t_cmd'($urandom_range(0, 3)), 8'($urandom), $urandom, 1'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // plain text, zero bytes, percent escapes and the disarming cases
    task automatic test_plain_and_percent();
        send_fmt(CH_UP_A);
        send_fmt(CH_NUL);                       // swallowed while idle
        send_fmt(8'hFF);
        send_fmt(CH_PERCENT);
        send_fmt(CH_PERCENT);                   // %% gives one percent
        send_fmt(CH_PERCENT);
        send_fmt(CH_P);                         // %p gives nothing
        send_fmt(CH_PERCENT);
        send_fmt(CH_Q);                         // unknown letter gives nothing
        send_fmt(CH_PERCENT);
        send_fmt(CH_NUL);                       // zero byte while armed disarms
        send_fmt(CH_PERCENT);
        send_end();                             // trailing percent dropped, count reported
    endtask

    // every conversion, its extremes and the ignored out-of-phase requests
    task automatic test_conversions();
        send_arg(32'hFFFF_FFFF);                // no word pending
        send_str(CH_LO_H, 1'b1);                // no string pending
        send_fmt(CH_PERCENT);
        send_fmt(CH_C);
        send_fmt(CH_LO_Z);                      // ignored, word still pending
        send_arg(32'h0000_0000);                // zero character is still counted
        send_fmt(CH_PERCENT);
        send_fmt(CH_D);
        send_arg(32'h8000_0000);                // most negative value
        send_fmt(CH_PERCENT);
        send_fmt(CH_I);
        send_arg(32'h0000_0000);
        send_fmt(CH_PERCENT);
        send_fmt(CH_U);
        send_arg(32'hFFFF_FFFF);
        send_fmt(CH_PERCENT);
        send_fmt(CH_X_LO);
        send_arg(32'hDEAD_BEEF);
        send_fmt(CH_PERCENT);
        send_fmt(CH_X_UP);
        send_arg(32'h00AB_CDEF);
        send_fmt(CH_PERCENT);
        send_fmt(CH_S);
        send_str(CH_NUL, 1'b0);                 // zero string byte emits nothing
        send_str(CH_LO_H, 1'b1);
        send_fmt(CH_PERCENT);
        send_fmt(CH_D);
        send_end();                             // pending conversion dropped
    endtask

    // a long stretch with neither side idling
    task automatic test_back_to_back();
        int start;
        gaps_on = 1'b0;
        start   = items_sent;
        while (items_sent - start < 40)
            send_random_segment();
        gaps_on = 1'b1;
    endtask

    // the receiver holds off while wide decimals keep coming, so the input must stall
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_gen++;
        repeat (6) begin
            send_fmt(CH_PERCENT);
            send_fmt(CH_D);
            send_arg($urandom);
            send_fmt(CH_STAR);
        end
        send_end();
    endtask

    task automatic test_random_formats();
        while (items_sent < ITEM_TARGET)
            send_random_segment();
        send_end();
    endtask

    initial begin
        req_if.valid       = 1'b0;
        req_if.command     = CMD_FORMAT;
        req_if.byte_value  = '0;
        req_if.arg_word    = '0;
        req_if.string_last = 1'b0;
        res_if.ready       = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_and_percent();
        wait_drained();
        test_conversions();
        wait_drained();
        test_back_to_back();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random_formats();
        wait_drained();

        // anything arriving now is an extra result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
